@@ rtl/b2dec_pkg.sv @@
// shared constants for the binary to decimal ascii converter
`default_nettype none

package b2dec_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 6;
  localparam int DIGIT_W        = 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_STEPS      = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE = 6'd57;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  // widest digit count a 32-bit value needs
  localparam int FULL_DIGITS = 10;

endpackage : b2dec_pkg

`default_nettype wire

@@ rtl/binary_to_decimal_ascii.sv @@
// binary to decimal ascii converter: pipelined double dabble and digit serializer
//
//  channel | ports                         | direction | meaning
//  --------+-------------------------------+-----------+-------------------------------
//  input   | in_valid in_stall in_value    | in        | one 32-bit unsigned value
//  result  | out_valid out_stall           | out       | one ascii digit, msd first,
//          | out_character out_last        |           | last marks end of the run
//
//  a value passes one saturate stage, NUM_STEPS double dabble stages of four bits
//  each and one leading zero stage before it reaches the serializer.
//  the serializer then sends one digit per cycle while out_stall is low: a value gives
//  as many digits as it has decimal digits (1 to 10 with the default MAX_DIGITS).
//  a new value enters every cycle while pipeline stages are free; bubbles close up.
//  out_stall holds the current digit and backs up through the stages to in_stall.
//  rst_n is synchronous and clears the valid bits only.
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [b2dec_pkg::VALUE_W-1:0]    in_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [b2dec_pkg::CHAR_W-1:0]     out_character,
  output logic                             out_last
);

  localparam int NDIG  = (MAX_DIGITS < b2dec_pkg::FULL_DIGITS) ? MAX_DIGITS
                                                             : b2dec_pkg::FULL_DIGITS;
  localparam int BCD_W = NDIG * b2dec_pkg::DIGIT_W;
  localparam int DW    = BCD_W + b2dec_pkg::VALUE_W;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int NST   = b2dec_pkg::NUM_STEPS;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam logic [63:0] SAT_MAX = (MAX_DIGITS < b2dec_pkg::FULL_DIGITS) ?
                                    pow10(NDIG) - 64'd1 : 64'hFFFF_FFFF;

  // four shift-and-adjust steps on {bcd, remaining binary}
  function automatic logic [DW-1:0] dabble(input logic [DW-1:0] d);
    logic [DW-1:0] t;
    t = d;
    for (int s = 0; s < b2dec_pkg::BITS_PER_STAGE; s++) begin
      for (int g = 0; g < NDIG; g++) begin
        if (t[b2dec_pkg::VALUE_W + g*b2dec_pkg::DIGIT_W +: b2dec_pkg::DIGIT_W]
            >= b2dec_pkg::BCD_ADJ_MIN) begin
          t[b2dec_pkg::VALUE_W + g*b2dec_pkg::DIGIT_W +: b2dec_pkg::DIGIT_W] =
            t[b2dec_pkg::VALUE_W + g*b2dec_pkg::DIGIT_W +: b2dec_pkg::DIGIT_W]
            + b2dec_pkg::BCD_ADJ_ADD;
        end
      end
      t = t << 1;
    end
    return t;
  endfunction

  logic [NST:0]    stg_valid_r;
  logic [DW-1:0]   stg_data_r [0:NST];
  logic [NST:0]    stg_adv;

  logic               cnt_valid_r;
  logic [BCD_W-1:0]   cnt_bcd_r;
  logic [IDX_W-1:0]   cnt_idx_r;
  logic [IDX_W-1:0]   cnt_idx_nxt;
  logic               cnt_adv;

  logic               ser_valid_r;
  logic [BCD_W-1:0]   ser_bcd_r;
  logic [IDX_W-1:0]   ser_idx_r;
  logic               ser_first_r;
  logic               ser_done;
  logic               ser_load;

  logic [b2dec_pkg::VALUE_W-1:0] sat_value;

  // handshake and advance chain
  assign ser_done = ser_valid_r && (ser_idx_r == '0) && !out_stall;
  assign ser_load = !ser_valid_r || ser_done;
  assign cnt_adv  = !cnt_valid_r || ser_load;

  always_comb begin
    stg_adv[NST] = !stg_valid_r[NST] || cnt_adv;
    for (int k = NST - 1; k >= 0; k--) begin
      stg_adv[k] = !stg_valid_r[k] || stg_adv[k+1];
    end
  end

  assign in_stall = !stg_adv[0];

  // saturate values too wide for the digit count
  always_comb begin
    if ({32'd0, in_value} > SAT_MAX) begin
      sat_value = SAT_MAX[b2dec_pkg::VALUE_W-1:0];
    end else begin
      sat_value = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r[0] <= 1'b0;
    end else if (stg_adv[0]) begin
      stg_valid_r[0] <= in_valid;
    end
    if (stg_adv[0] && in_valid) begin
      stg_data_r[0] <= {{BCD_W{1'b0}}, sat_value};
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_dabble
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_valid_r[k] <= 1'b0;
      end else if (stg_adv[k]) begin
        stg_valid_r[k] <= stg_valid_r[k-1];
      end
      if (stg_adv[k] && stg_valid_r[k-1]) begin
        stg_data_r[k] <= dabble(stg_data_r[k-1]);
      end
    end
  end

  // position of the most significant nonzero digit, zero gives position 0
  always_comb begin
    cnt_idx_nxt = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (stg_data_r[NST][b2dec_pkg::VALUE_W + i*b2dec_pkg::DIGIT_W +: b2dec_pkg::DIGIT_W]
          != '0) begin
        cnt_idx_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_valid_r <= 1'b0;
    end else if (cnt_adv) begin
      cnt_valid_r <= stg_valid_r[NST];
    end
    if (cnt_adv && stg_valid_r[NST]) begin
      cnt_bcd_r <= stg_data_r[NST][DW-1:b2dec_pkg::VALUE_W];
      cnt_idx_r <= cnt_idx_nxt;
    end
  end

  // serializer: one digit per transaction, counting down to the units digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
    end else if (ser_load) begin
      ser_valid_r <= cnt_valid_r;
    end
    if (ser_load) begin
      if (cnt_valid_r) begin
        ser_bcd_r   <= cnt_bcd_r;
        ser_idx_r   <= cnt_idx_r;
        ser_first_r <= 1'b1;
      end
    end else if (!out_stall) begin
      ser_idx_r   <= ser_idx_r - IDX_W'(1);
      ser_first_r <= 1'b0;
    end
  end

  assign out_valid     = ser_valid_r;
  assign out_last      = (ser_idx_r == '0);
  assign out_character = b2dec_pkg::ASCII_ZERO +
    {2'b00, ser_bcd_r[ser_idx_r*b2dec_pkg::DIGIT_W +: b2dec_pkg::DIGIT_W]};

  // a run never opens with a suppressed zero
  a_no_leading_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (ser_valid_r && ser_first_r && !out_last) |-> (out_character != b2dec_pkg::ASCII_ZERO))
    else $error("leading zero in digit run");

  a_digit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character >= b2dec_pkg::ASCII_ZERO) &&
                   (out_character <= b2dec_pkg::ASCII_NINE)))
    else $error("character outside decimal digits");

  a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && !ser_first_r && (ser_idx_r == $past(ser_idx_r) - IDX_W'(1))))
    else $error("digit run broken before its last digit");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stg_valid_r[0])
    else $error("accepted value lost at pipeline entry");

  a_no_drop_at_count : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_valid_r && !ser_load) |=> cnt_valid_r && $stable(cnt_bcd_r))
    else $error("held value in count stage changed");

endmodule : binary_to_decimal_ascii

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the binary to decimal ascii converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_ITEMS = 40;
  localparam int unsigned RANDOM_ITEMS = 390;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [b2dec_pkg::CHAR_W-1:0] character;
    logic                         last;
  } digit_t;

  typedef struct {
    logic [b2dec_pkg::VALUE_W-1:0] value;
    string                         text;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [b2dec_pkg::VALUE_W-1:0] in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [b2dec_pkg::CHAR_W-1:0]  out_character;
  logic                          out_last;

  digit_t      expected_digits[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned values_sent;
  int unsigned digits_checked;
  int unsigned input_stall_cycles;
  bit [10:1]   run_len_seen;
  bit          in_idle_en;
  bit          out_idle_en;
  bit          hold_request;

  binary_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // decimal text of one value, msd first, leading zeros dropped
  function automatic void push_decimal_digits(input logic [b2dec_pkg::VALUE_W-1:0] v);
    logic [63:0]        rest;
    logic [63:0]        weight;
    logic [63:0]        d;
    bit                 started;
    int unsigned        n;
    rest = 64'(v);
    weight = 64'd1000000000;
    started = 1'b0;
    n = 0;
    if (v == '0) begin
      expected_digits.push_back('{b2dec_pkg::ASCII_ZERO, 1'b1});
      run_len_seen[1] = 1'b1;
      return;
    end
    for (int pos = 0; pos < b2dec_pkg::FULL_DIGITS; pos++) begin
      d = rest / weight;
      if (started || d != 0) begin
        started = 1'b1;
        rest = rest - d * weight;
        expected_digits.push_back('{b2dec_pkg::ASCII_ZERO +
                                    b2dec_pkg::CHAR_W'(d[b2dec_pkg::DIGIT_W-1:0]), 1'b0});
        n++;
      end
      weight = weight / 10;
    end
    expected_digits[$].last = 1'b1;
    run_len_seen[n] = 1'b1;
  endfunction

  function automatic void push_typed_text(input string text);
    for (int i = 0; i < text.len(); i++)
      expected_digits.push_back('{b2dec_pkg::CHAR_W'(text[i]), i == text.len() - 1});
    run_len_seen[text.len()] = 1'b1;
  endfunction

  // mostly zero, some short, a few long
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [b2dec_pkg::VALUE_W-1:0] pick_value();
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned n;
    int unsigned kind;
    kind = $urandom_range(9, 0);
    if (kind < 6) begin
      // uniform over the run length, then over the values of that length
      n = $urandom_range(10, 1);
      lo = 1;
      for (int i = 1; i < n; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n == 1) lo = 0;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return $urandom_range(32'(hi), 32'(lo));
    end else if (kind < 8) begin
      return $urandom();
    end else if (kind == 8) begin
      // power of ten and its neighbors
      lo = 1;
      n = $urandom_range(9, 0);
      for (int i = 0; i < n; i++) lo = lo * 10;
      return 32'(lo + $urandom_range(2, 0) - 1);
    end else begin
      n = $urandom_range(b2dec_pkg::VALUE_W - 1, 0);
      case ($urandom_range(2, 0))
        0:       return 32'd1 << n;
        1:       return ~(32'd1 << n);
        default: return 32'hFFFF_FFFF - $urandom_range(15, 0);
      endcase
    end
  endfunction

  // holds valid and the value until the transaction is taken
  task automatic offer_value(input logic [b2dec_pkg::VALUE_W-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    values_sent++;
  endtask

  task automatic sender_idle();
    int unsigned gap;
    gap = in_idle_en ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls and the long hold-off
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (out_idle_en) stall_left = pick_idle_len();
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    digit_t want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit %0d last %0b", out_character, out_last));
      end else begin
        want = expected_digits.pop_front();
        if (out_character !== want.character)
          report_mismatch($sformatf("character %0d, expected %0d",
                                    out_character, want.character));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        digits_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding",
               cycle_count, expected_digits.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    hold_request = 1'b0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    mismatch_count = 0;
    cycle_count = 0;
    values_sent = 0;
    digits_checked = 0;
    input_stall_cycles = 0;
    run_len_seen = '0;

    // empty text means the predictor supplies the digits
    directed_rows.push_back('{32'd0, "0"});
    directed_rows.push_back('{32'd9, "9"});
    directed_rows.push_back('{32'd10, "10"});
    directed_rows.push_back('{32'hFFFF_FFFF, "4294967295"});
    directed_rows.push_back('{32'd1000000000, "1000000000"});
    directed_rows.push_back('{32'd1, "1"});
    directed_rows.push_back('{32'd99, ""});
    directed_rows.push_back('{32'd100, ""});
    directed_rows.push_back('{32'd999999999, ""});
    directed_rows.push_back('{32'h8000_0000, ""});
    directed_rows.push_back('{32'h7FFF_FFFF, ""});
    directed_rows.push_back('{32'd1234567890, ""});
    directed_rows.push_back('{32'd4000000000, ""});
    directed_rows.push_back('{32'hFFFF_FFFE, ""});
    directed_rows.push_back('{32'd1000000001, ""});
    directed_rows.push_back('{32'h5555_5555, ""});
    directed_rows.push_back('{32'hAAAA_AAAA, ""});
    directed_rows.push_back('{32'd100000, ""});
    directed_rows.push_back('{32'd0, "0"});
    directed_rows.push_back('{32'd5, "5"});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_value(directed_rows[i].value);
      if (directed_rows[i].text.len() == 0) push_decimal_digits(directed_rows[i].value);
      else push_typed_text(directed_rows[i].text);
      sender_idle();
    end

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      logic [b2dec_pkg::VALUE_W-1:0] v;
      // back to back on both sides for a while
      if (k == 150) begin
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
      end
      // receiver holds off while values keep coming, filling the pipeline
      if (k == 250) begin
        hold_request = 1'b1;
        for (int unsigned h = 0; h < HOLD_ITEMS; h++) begin
          v = pick_value();
          offer_value(v);
          push_decimal_digits(v);
        end
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
      end
      if (k == 330) begin
        wait_for_drain();
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
      v = pick_value();
      offer_value(v);
      push_decimal_digits(v);
      sender_idle();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_digits.size() != 0)
      report_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));
    $display("converted %0d values, %0d digits checked, run lengths seen %b (10..1)",
             values_sent, digits_checked, run_len_seen);
    $display("input held back on %0d cycles, including a %0d cycle receiver hold-off",
             input_stall_cycles, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
